// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/cppd_pkg.sv =====
// ----------------------------------------------------------------------------
// cppd_pkg
// Shared types and constants of the cardiac phase peak detector.
// ----------------------------------------------------------------------------
package cppd_pkg;
	localparam int MAX_HISTORY = 128;
	localparam int HIST_AW = $clog2(MAX_HISTORY);
	localparam int CNT_W = HIST_AW + 1;
	localparam int AREA_W = 20;
	localparam int TOTAL_W = AREA_W + CNT_W - 1;
	localparam int OFS_W = 8;
	localparam int MARK_LIMIT = 128;

	localparam logic [1:0] REG_HIST_LEN = 2'd0;
	localparam logic [1:0] REG_SPAN = 2'd1;
	localparam logic [1:0] REG_GAP = 2'd2;
	localparam logic [1:0] REG_EXCL = 2'd3;

	typedef struct packed {
		logic [7:0] hist_len;
		logic [6:0] span;
		logic [6:0] gap;
		logic excl;
	} cfg_t;

	typedef struct packed {
		logic peak_found;
		logic [OFS_W-1:0] peak_offset;
		logic trough_found;
		logic [OFS_W-1:0] trough_offset;
		logic [15:0] history_max;
		logic [15:0] history_min;
		logic [AREA_W-1:0] history_mean;
	} result_t;
endpackage

// ===== rtl/cardiac_phase_peak_detector.sv =====
// ----------------------------------------------------------------------------
// cardiac_phase_peak_detector
// Per-frame area statistics and end-diastole / end-systole peak picking.
// ----------------------------------------------------------------------------
// One item is handled at a time. Each item trims the oldest samples from the
// history (usually one) and appends the new one; then the history memory's
// single read port sweeps every held sample once, and a bit-serial divider
// forms the mean.
// A new item may be taken while the previous result still waits; that item
// only completes once the waiting result has been handed over.
`include "assert_macros.svh"
module cardiac_phase_peak_detector (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata, // [19:0] area_sample
	output logic m_tvalid,
	input logic m_tready,
	// [0] peak_found [8:1] peak_offset [9] trough_found [17:10] trough_offset
	// [33:18] history_max [49:34] history_min [69:50] history_mean
	output logic [71:0] m_tdata
);
	cppd_pkg::cfg_t cfg_q;
	cppd_pkg::result_t res;
	logic wr;
	logic [1:0] ridx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hist_len <= 8'd101;
			cfg_q.span <= 7'd30;
			cfg_q.gap <= 7'd5;
			cfg_q.excl <= 1'b1;
		end else if (wr) begin
			case (ridx)
				cppd_pkg::REG_HIST_LEN: cfg_q.hist_len <= pwdata[7:0];
				cppd_pkg::REG_SPAN: cfg_q.span <= pwdata[6:0];
				cppd_pkg::REG_GAP: cfg_q.gap <= pwdata[6:0];
				cppd_pkg::REG_EXCL: cfg_q.excl <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			cppd_pkg::REG_HIST_LEN: prdata = {24'd0, cfg_q.hist_len};
			cppd_pkg::REG_SPAN: prdata = {25'd0, cfg_q.span};
			cppd_pkg::REG_GAP: prdata = {25'd0, cfg_q.gap};
			cppd_pkg::REG_EXCL: prdata = {31'd0, cfg_q.excl};
			default: prdata = '0;
		endcase
	end

	cppd_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_area(s_tdata[19:0]),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {2'b00, res.history_mean, res.history_min, res.history_max,
		res.trough_offset, res.trough_found, res.peak_offset, res.peak_found};

	`ASSERT_CLK(a_excl, clk, arst_n, !(m_tvalid && cfg_q.excl && m_tdata[0] && m_tdata[9]), "both phases reported in exclusive mode")
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`ASSERT_NEXT(a_seq, clk, arst_n, s_tvalid && s_tready, !s_tready, "new item taken while busy")
endmodule

// ===== rtl/cppd_ram.sv =====
// ----------------------------------------------------------------------------
// cppd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cppd_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 20,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cppd_div.sv =====
// ----------------------------------------------------------------------------
// cppd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cppd_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [cppd_pkg::TOTAL_W-1:0] dividend,
	input logic [cppd_pkg::CNT_W-1:0] divisor,
	output logic busy,
	output logic [cppd_pkg::TOTAL_W-1:0] quotient
);
	localparam int CW = $clog2(cppd_pkg::TOTAL_W + 1);
	logic [CW-1:0] cnt_q;
	logic [cppd_pkg::TOTAL_W-1:0] quo_q;
	logic [cppd_pkg::CNT_W:0] rem_q;
	logic [cppd_pkg::CNT_W-1:0] dsr_q;
	logic [cppd_pkg::CNT_W:0] trial;

	assign trial = {rem_q[cppd_pkg::CNT_W-1:0], quo_q[cppd_pkg::TOTAL_W-1]};
	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(cppd_pkg::TOTAL_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[cppd_pkg::TOTAL_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[cppd_pkg::TOTAL_W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/cppd_core.sv =====
// ----------------------------------------------------------------------------
// cppd_core
// Sequencer: trims, appends, scans the history memory, divides, decides.
// ----------------------------------------------------------------------------
module cppd_core (
	input logic clk,
	input logic arst_n,
	input cppd_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [cppd_pkg::AREA_W-1:0] in_area,
	output logic res_valid,
	input logic res_ready,
	output cppd_pkg::result_t res
);
	localparam int AW = cppd_pkg::HIST_AW;
	localparam int CW = cppd_pkg::CNT_W;
	localparam int AWD = cppd_pkg::AREA_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_TRIM = 7'b0000010,
		ST_TRIMW = 7'b0000100,
		ST_WRITE = 7'b0001000,
		ST_SCAN = 7'b0010000,
		ST_DIV = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] fill_q;
	logic [cppd_pkg::TOTAL_W-1:0] total_q;
	logic signed [8:0] pmark_q, tmark_q;
	logic [AWD-1:0] area_q;
	logic [CW-1:0] limit;
	logic [CW-1:0] k_q;
	logic rd_ok_s1;
	logic [CW-1:0] k_s1;
	logic [AWD-1:0] hi_q, lo_q, w0_q, w1_q;
	logic [1:0] wcnt_q;
	logic have_p_q, have_t_q;
	logic [AWD-1:0] pval_q, tval_q;
	logic [CW-1:0] pidx_q, tidx_q;
	logic signed [CW:0] last_v;
	logic [CW-1:0] last_idx;
	logic div_start, div_busy, div_started_q;
	logic [cppd_pkg::TOTAL_W-1:0] quot;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [AWD-1:0] wdata, rdata;
	logic out_valid_q;
	cppd_pkg::result_t res_q;

	cppd_ram #(.DEPTH(cppd_pkg::MAX_HISTORY), .WIDTH(AWD)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	cppd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(total_q),
		.divisor(fill_q), .busy(div_busy), .quotient(quot)
	);

	always_comb begin
		if (cfg.hist_len < 8'd3) limit = CW'(3);
		else if ({1'b0, cfg.hist_len} > 9'(cppd_pkg::MAX_HISTORY))
			limit = CW'(cppd_pkg::MAX_HISTORY);
		else limit = CW'(cfg.hist_len);
		last_v = $signed({1'b0, fill_q}) - $signed((CW+1)'(cfg.span));
		if (last_v < 1) last_idx = CW'(1);
		else last_idx = last_v[CW-1:0];
	end

	assign we = (state_q == ST_WRITE);
	assign waddr = AW'(oldest_q + fill_q[AW-1:0]);
	assign wdata = area_q;
	assign raddr = (state_q == ST_TRIM) ? oldest_q : AW'(oldest_q + k_q[AW-1:0]);
	assign div_start = (state_q == ST_DIV) && !div_started_q;
	assign in_ready = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;
	assign res = res_q;

	// candidate index in w1 when rdata holds index k_s1
	logic [CW-1:0] cidx;
	logic signed [8:0] pcand, tcand, pm_age, tm_age;
	logic pok, tok;
	assign cidx = k_s1 - CW'(1);

	function automatic logic signed [8:0] age(input logic signed [8:0] m,
		input logic [CW-1:0] fill);
		logic signed [8:0] n;
		n = m - 9'sd1;
		if (m >= 0) return m;
		if ((-n) >= $signed({1'b0, 8'(fill)}) || (-n) >= 9'sd128) return 9'sd1;
		return n;
	endfunction

	always_comb begin
		pm_age = age(pmark_q, fill_q);
		tm_age = age(tmark_q, fill_q);
		pcand = $signed({1'b0, 8'(pidx_q)}) - $signed({1'b0, 8'(fill_q)});
		tcand = $signed({1'b0, 8'(tidx_q)}) - $signed({1'b0, 8'(fill_q)});
		pok = have_p_q && (pm_age >= 0 || pcand > pm_age + $signed({2'b0, cfg.gap}));
		tok = have_t_q && (tm_age >= 0 || tcand > tm_age + $signed({2'b0, cfg.gap}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oldest_q <= '0;
			fill_q <= '0;
			total_q <= '0;
			pmark_q <= 9'sd1;
			tmark_q <= 9'sd1;
			out_valid_q <= 1'b0;
			div_started_q <= 1'b0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			rd_ok_s1 <= (state_q == ST_SCAN) && (k_q < fill_q);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (fill_q >= limit) state_q <= ST_TRIMW;
					else state_q <= ST_WRITE;
				end
				ST_TRIMW: begin
					total_q <= total_q - cppd_pkg::TOTAL_W'(rdata);
					oldest_q <= oldest_q + 1'b1;
					fill_q <= fill_q - 1'b1;
					state_q <= ST_TRIM;
				end
				ST_WRITE: begin
					fill_q <= fill_q + 1'b1;
					total_q <= total_q + cppd_pkg::TOTAL_W'(area_q);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (k_q >= fill_q && !rd_ok_s1) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_started_q && !div_busy && !out_valid_q) begin
						div_started_q <= 1'b0;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						pmark_q <= pok ? pcand : pm_age;
						tmark_q <= tok ? tcand : tm_age;
					end else begin
						div_started_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (state_q == ST_IDLE) area_q <= in_area;
		if (state_q == ST_WRITE) begin
			k_q <= '0;
			hi_q <= '0;
			lo_q <= '1;
			wcnt_q <= '0;
			have_p_q <= 1'b0;
			have_t_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (k_q < fill_q) k_q <= k_q + 1'b1;
			if (rd_ok_s1) begin
				if (rdata > hi_q) hi_q <= rdata;
				if (rdata < lo_q) lo_q <= rdata;
				w0_q <= w1_q;
				w1_q <= rdata;
				if (wcnt_q != 2'd2) wcnt_q <= wcnt_q + 1'b1;
				// window: w0 = cidx-1, w1 = cidx, rdata = cidx+1
				if (wcnt_q == 2'd2 && cidx >= last_idx && cidx <= fill_q - CW'(2)) begin
					if (w0_q < w1_q && rdata < w1_q && (!have_p_q || w1_q >= pval_q)) begin
						have_p_q <= 1'b1;
						pval_q <= w1_q;
						pidx_q <= cidx;
					end
					if (w0_q > w1_q && rdata > w1_q && (!have_t_q || w1_q <= tval_q)) begin
						have_t_q <= 1'b1;
						tval_q <= w1_q;
						tidx_q <= cidx;
					end
				end
			end
		end
		if (state_q == ST_DIV && div_started_q && !div_busy && !out_valid_q) begin
			res_q.peak_found <= pok && !(cfg.excl && tok && !(pcand > tcand));
			res_q.trough_found <= tok && !(cfg.excl && pok && (pcand > tcand));
			res_q.peak_offset <= (pok && !(cfg.excl && tok && !(pcand > tcand)))
				? pcand[7:0] : '0;
			res_q.trough_offset <= (tok && !(cfg.excl && pok && (pcand > tcand)))
				? tcand[7:0] : '0;
			res_q.history_max <= hi_q[AWD-1:4];
			res_q.history_min <= lo_q[AWD-1:4];
			res_q.history_mean <= quot[AWD-1:0];
		end
	end
endmodule
